@@ rtl/ripts_pkg.sv @@
package ripts_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned LINE_W  = 5;
	localparam int unsigned CAUSE_W = 5;

	// item kinds
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CHECK = 2'd3;

	// csr views
	localparam logic [LINE_W-1:0] CSR_MIP = 5'd0;
	localparam logic [LINE_W-1:0] CSR_MIE = 5'd1;
	localparam logic [LINE_W-1:0] CSR_SIP = 5'd2;
	localparam logic [LINE_W-1:0] CSR_SIE = 5'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_DELEG  = 2'd0;
	localparam logic [1:0] CFG_MTVEC  = 2'd1;
	localparam logic [1:0] CFG_STVEC  = 2'd2;
	localparam logic [1:0] CFG_DBGPC  = 2'd3;

	localparam logic [1:0] PRIV_S = 2'd1;
	localparam logic [1:0] PRIV_M = 2'd3;

	localparam logic [DATA_W-1:0] MIP_WRITE_MASK = 32'h0000_0AAA;
	localparam logic [DATA_W-1:0] SUPER_MASK     = 32'h0000_0222;

	typedef struct packed {
		logic [1:0]        kind;
		logic [LINE_W-1:0] target;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        priv_mode;
		logic              status_mie;
		logic              status_sie;
		logic              global_enable;
		logic              wake_blocked;
		logic              debug_request;
		logic              in_debug_mode;
		logic [DATA_W-1:0] current_pc;
	} irq_in_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               wake;
		logic               trap_taken;
		logic               debug_entered;
		logic               to_supervisor;
		logic [CAUSE_W-1:0] cause_code;
		logic [DATA_W-1:0]  next_pc;
		logic [DATA_W-1:0]  saved_pc;
		logic [1:0]         saved_mode;
		logic               saved_enable;
	} irq_out_t;

endpackage

@@ rtl/riscv_interrupt_pending_and_trap_select.sv @@
// Interrupt pending/enable store and trap selection for a RISC-V hart. The block
// holds mip and mie (both cleared by reset) and takes one item per clock: a line
// level change, a csr write, a csr read, or an instruction-boundary check that
// enters debug mode, traps to M or S mode, or does nothing. Each item yields exactly
// one result item, presented on the result port after it has passed through the
// input register and then the result register; the state update of one item is
// seen by the next, so items may follow back to back at one per cycle with no
// bubble. Stalls on the result side hold the result register and, once the input
// register is also full, drop ready.
// The four configuration registers (delegation mask, machine vector, supervisor
// vector, debug handler address) are written through cfg_we/cfg_index/cfg_wdata
// and must only change while no item is in flight.
module riscv_interrupt_pending_and_trap_select (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ripts_pkg::irq_in_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ripts_pkg::irq_out_t  out_item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_wdata
);
	import ripts_pkg::*;

	// configuration
	logic [DATA_W-1:0] deleg_q, mtvec_q, stvec_q, dbgpc_q;

	// architectural state
	logic [DATA_W-1:0] pend_q, ena_q;
	logic [DATA_W-1:0] pend_nxt, ena_nxt;

	// pipeline
	logic     valid_s1, valid_s2;
	irq_in_t  item_s1;
	irq_out_t res_s2;
	irq_out_t res;
	logic     advance;

	// decision terms
	logic [DATA_W-1:0]  act, en_m, en_s, en_sel, line_bit;
	logic               line_used, m_ok, s_ok, use_sup;
	logic [CAUSE_W-1:0] cause;

	// Advance the input stage whenever the result register is free or drains now.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deleg_q <= '0;
			mtvec_q <= '0;
			stvec_q <= '0;
			dbgpc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELEG: deleg_q <= cfg_wdata;
				CFG_MTVEC: mtvec_q <= {cfg_wdata[DATA_W-1:1], 1'b0};
				CFG_STVEC: stvec_q <= {cfg_wdata[DATA_W-1:1], 1'b0};
				CFG_DBGPC: dbgpc_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Input register: hold the item until the result stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Result register and state commit: both move when the item leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pend_q   <= '0;
			ena_q    <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pend_q <= pend_nxt;
				ena_q  <= ena_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	// Lines 3, 7, 9, 11 and everything from 12 up are wired; others are ignored.
	assign line_used = (item_s1.target == 5'd3) || (item_s1.target == 5'd7) ||
		(item_s1.target == 5'd9) || (item_s1.target == 5'd11) ||
		(item_s1.target >= 5'd12);
	assign line_bit  = {{(DATA_W-1){1'b0}}, 1'b1} << item_s1.target;

	// Privilege compares as a number, so the reserved level 2 enables M but not S.
	assign act     = ena_q & pend_q;
	assign en_m    = act & ~deleg_q;
	assign m_ok    = (item_s1.priv_mode == PRIV_M && item_s1.status_mie) ||
		(item_s1.priv_mode < PRIV_M);
	assign s_ok    = (item_s1.priv_mode == PRIV_S && item_s1.status_sie) ||
		(item_s1.priv_mode < PRIV_S);
	assign use_sup = (en_m == '0) || !m_ok;
	assign en_s    = s_ok ? (act & deleg_q) : '0;
	assign en_sel  = use_sup ? en_s : en_m;

	// Cause: fixed order 11, 3, 7, 9, 1, 5, then the lowest set bit.
	always_comb begin
		cause = '0;
		priority if (en_sel[11]) cause = 5'd11;
		else if (en_sel[3])      cause = 5'd3;
		else if (en_sel[7])      cause = 5'd7;
		else if (en_sel[9])      cause = 5'd9;
		else if (en_sel[1])      cause = 5'd1;
		else if (en_sel[5])      cause = 5'd5;
		else begin
			for (int i = DATA_W - 1; i >= 0; i--) begin
				if (en_sel[i]) begin
					cause = CAUSE_W'(i);
				end
			end
		end
	end

	always_comb begin
		pend_nxt = pend_q;
		ena_nxt  = ena_q;
		res      = '0;
		unique case (item_s1.kind)
			KIND_LINE: begin
				if (line_used) begin
					pend_nxt = item_s1.write_data[0] ? (pend_q | line_bit) :
						(pend_q & ~line_bit);
				end
			end
			KIND_WRITE: begin
				unique case (item_s1.target)
					CSR_MIP: pend_nxt = item_s1.write_data & MIP_WRITE_MASK;
					CSR_MIE: ena_nxt  = item_s1.write_data;
					CSR_SIP: pend_nxt = (pend_q & ~SUPER_MASK) |
						(item_s1.write_data & SUPER_MASK);
					CSR_SIE: ena_nxt  = (ena_q & ~SUPER_MASK) |
						(item_s1.write_data & SUPER_MASK);
					default: ;
				endcase
			end
			KIND_READ: begin
				unique case (item_s1.target)
					CSR_MIP: res.read_data = pend_q;
					CSR_MIE: res.read_data = ena_q;
					CSR_SIP: res.read_data = pend_q & SUPER_MASK;
					CSR_SIE: res.read_data = ena_q & SUPER_MASK;
					default: res.read_data = '0;
				endcase
			end
			KIND_CHECK: begin
				if (item_s1.debug_request && !item_s1.in_debug_mode) begin
					res.debug_entered = 1'b1;
					res.next_pc       = dbgpc_q;
					res.saved_pc      = item_s1.current_pc;
					res.saved_enable  = item_s1.global_enable;
				end else if (en_sel != '0) begin
					res.trap_taken    = 1'b1;
					res.to_supervisor = use_sup;
					res.cause_code    = cause;
					res.next_pc       = use_sup ? stvec_q : mtvec_q;
					res.saved_pc      = item_s1.current_pc;
					res.saved_mode    = item_s1.priv_mode;
					res.saved_enable  = item_s1.global_enable;
				end
			end
			default: ;
		endcase
		// Wake looks at the state as this item leaves it.
		res.wake = ((ena_nxt & pend_nxt) != '0) && !item_s1.wake_blocked;
	end

`ifndef SYNTHESIS
	// Bits 0, 2, 4, 6, 8 and 10 can never become pending.
	a_unused_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & 32'h0000_0555) == '0)
		else $error("pending bit set on an unwired line");

	// A check enters debug or traps, never both.
	a_one_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.trap_taken && out_item.debug_entered))
		else $error("trap and debug entry on the same item");

	// Trap vectors always have bit 0 clear.
	a_vector_align: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.trap_taken) |-> !out_item.next_pc[0])
		else $error("trap vector with bit 0 set");

	// An empty result register never blocks input.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register empty");
`endif

endmodule
